// ===== src/fbam_pkg.sv =====
`default_nettype none
package fbam_pkg;

    localparam int unsigned MAP_BITS_DEFAULT  = 1024;
    localparam int unsigned CFG_W             = 11;
    localparam int unsigned INDEX_W           = 10;
    localparam int unsigned WORD_W            = 32;
    localparam int unsigned WORD_LW           = 5;
    localparam logic [CFG_W-1:0] BITS_IN_USE_RESET = 11'd1024;

    localparam logic [1:0] CMD_FIND  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_TEST  = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [INDEX_W-1:0] bit_index;
    } t_req;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] free_index;
        logic               bit_value;
        logic               range_error;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_EVAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic eval;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic eval_done;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ===== src/fbam_ctrl.sv =====
`default_nettype none
module fbam_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fbam_pkg::t_dp_sts i_sts,
    output fbam_pkg::t_dp_cmd o_cmd
);
    import fbam_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.eval_done ? ST_DONE : ST_ISSUE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/fbam_dp.sv =====
`default_nettype none
module fbam_dp #(
    parameter int unsigned MAP_BITS = fbam_pkg::MAP_BITS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [fbam_pkg::CFG_W-1:0] i_cfg_data,
    input  fbam_pkg::t_req             i_in_data,
    input  fbam_pkg::t_dp_cmd          i_cmd,
    output fbam_pkg::t_dp_sts          o_sts,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output fbam_pkg::t_rsp             o_out_data
);
    import fbam_pkg::*;

    localparam int unsigned ROWS  = (MAP_BITS + WORD_W - 1) / WORD_W;
    localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned DEPTH = 1 << RW;
    localparam int unsigned CW0   = $clog2(MAP_BITS + 1);
    localparam int unsigned EW    = (CW0 > CFG_W) ? CW0 : CFG_W;
    localparam int unsigned XW    = EW + 1;
    localparam int unsigned HW    = RW + WORD_LW;
    localparam logic [EW-1:0] MAP_COUNT = EW'(MAP_BITS);

    logic [WORD_W-1:0]  r_mem [DEPTH];
    logic [WORD_W-1:0]  r_rdata;
    logic [RW-1:0]      r_row;
    logic [CFG_W-1:0]   r_bits_in_use;
    logic [1:0]         r_cmd;
    logic [WORD_LW-1:0] r_bit;
    logic               r_err;
    t_rsp               r_res;
    t_rsp               n_res;
    t_rsp               r_out;
    logic               r_out_valid;

    logic [EW-1:0]          cfg_ext;
    logic [EW-1:0]          eff_count;
    logic [EW-1:0]          idx_ext;
    logic [HW-1:0]          row_base;
    logic [XW-1:0]          rem;
    logic [WORD_W-1:0]      valid_mask;
    logic [WORD_W-1:0]      masked;
    logic [WORD_W-1:0]      bit_sel;
    logic                   any_free;
    logic                   last_row;
    logic [WORD_LW-1:0]     pos;
    logic [HW-1:0]          hit;
    logic [HW+INDEX_W-1:0]  hit_ext;
    logic                   eval_done;
    logic                   eval_wr;
    logic [WORD_W-1:0]      eval_wdata;
    logic                   mem_we;
    logic [WORD_W-1:0]      mem_wdata;

    // effective count and range check
    assign cfg_ext   = EW'(r_bits_in_use);
    assign eff_count = (cfg_ext > MAP_COUNT) ? MAP_COUNT : cfg_ext;
    assign idx_ext   = EW'(i_in_data.bit_index);

    // valid bits of the current row
    assign row_base = {r_row, WORD_LW'(0)};
    assign rem      = {1'b0, eff_count} - XW'(row_base);
    assign last_row = rem[XW-1] || (rem <= XW'(WORD_W));

    always_comb begin
        if (rem[XW-1] || (rem == '0)) begin
            valid_mask = '0;
        end else if (rem >= XW'(WORD_W)) begin
            valid_mask = '1;
        end else begin
            valid_mask = ~({WORD_W{1'b1}} << rem[WORD_LW-1:0]);
        end
    end

    assign masked   = r_rdata | ~valid_mask;
    assign any_free = ~&masked;

    always_comb begin
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!masked[i]) begin
                pos = WORD_LW'(i);
            end
        end
    end

    assign hit     = {r_row, pos};
    assign hit_ext = {INDEX_W'(0), hit};
    assign bit_sel = WORD_W'(1) << r_bit;

    always_comb begin
        n_res      = '0;
        eval_done  = 1'b1;
        eval_wr    = 1'b0;
        eval_wdata = r_rdata;
        if (r_err) begin
            n_res.range_error = 1'b1;
        end else begin
            case (r_cmd)
                CMD_FIND: begin
                    if (any_free) begin
                        n_res.found      = 1'b1;
                        n_res.free_index = hit_ext[INDEX_W-1:0];
                    end else if (!last_row) begin
                        eval_done = 1'b0;
                    end
                end
                CMD_SET: begin
                    eval_wr    = 1'b1;
                    eval_wdata = r_rdata | bit_sel;
                end
                CMD_CLEAR: begin
                    eval_wr    = 1'b1;
                    eval_wdata = r_rdata & ~bit_sel;
                end
                CMD_TEST: begin
                    n_res.bit_value = r_rdata[r_bit];
                end
                default: begin
                    n_res = '0;
                end
            endcase
        end
    end

    assign mem_we    = i_cmd.clear_wr || (i_cmd.eval && eval_wr);
    assign mem_wdata = i_cmd.clear_wr ? '0 : eval_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_row] <= mem_wdata;
        end
        r_rdata <= r_mem[r_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row         <= '0;
            r_bits_in_use <= BITS_IN_USE_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bits_in_use <= i_cfg_data;
            end
            if (i_cmd.clear_wr) begin
                r_row <= r_row + RW'(1);
            end else if (i_cmd.accept) begin
                r_row <= (i_in_data.command == CMD_FIND) ? '0 : idx_ext[WORD_LW +: RW];
            end else if (i_cmd.eval && !eval_done) begin
                r_row <= r_row + RW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd <= i_in_data.command;
            r_bit <= i_in_data.bit_index[WORD_LW-1:0];
            r_err <= (i_in_data.command != CMD_FIND) && (idx_ext >= eff_count);
        end
        if (i_cmd.eval && eval_done) begin
            r_res <= n_res;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_sts.clear_last = &r_row;
    assign o_sts.eval_done  = eval_done;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== src/free_bit_allocation_map_core.sv =====
// channel   direction  signals                                  payload
// request   in         i_in_valid / o_in_ready                  t_req: command, bit_index
// result    out        o_out_valid / i_out_ready                t_rsp: found, free_index,
//                                                                  bit_value, range_error
// config    in         i_cfg_valid / o_cfg_ready                i_cfg_data: bits_in_use
//
// set, clear, test and out-of-range requests pass once through the issue and evaluate states
// find repeats issue and evaluate once per 32-bit map row scanned in the single-port memory
// reset runs a clearing pass of one row per cycle, no requests taken
// the result register frees the request side: the next request transfers in the cycle after
// the result loads, while it waits; a second finished result stalls until the first leaves
// config writes are taken every cycle, including during the clearing pass
`default_nettype none
module free_bit_allocation_map_core #(
    parameter int unsigned MAP_BITS = fbam_pkg::MAP_BITS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [fbam_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  fbam_pkg::t_req             i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output fbam_pkg::t_rsp             o_out_data
);
    import fbam_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    fbam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    fbam_dp #(
        .MAP_BITS (MAP_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

// ===== test/free_bit_allocation_map_core_tb.sv =====
`default_nettype none
module free_bit_allocation_map_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fbam_pkg::*;

    localparam int unsigned MAP_BITS    = 1024;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_WAIT  = 80;

    class alloc_map_tracker;
        bit [MAP_BITS-1:0] used_bits;
        logic [CFG_W-1:0]  bits_in_use;
        t_rsp              pending_answers[$];
        int unsigned       mismatches;

        function new();
            used_bits   = '0;
            bits_in_use = BITS_IN_USE_RESET;
            mismatches  = 0;
        endfunction

        function int unsigned usable_bits();
            if (bits_in_use > MAP_BITS) return MAP_BITS;
            return bits_in_use;
        endfunction

        function int lowest_free();
            int unsigned limit;
            limit = usable_bits();
            for (int i = 0; i < limit; i++) begin
                if (!used_bits[i]) return i;
            end
            return -1;
        endfunction

        function int pending_count();
            return pending_answers.size();
        endfunction

        function void note_request(t_req req);
            t_rsp rsp;
            int   pos;
            rsp = '0;
            if (req.command == CMD_FIND) begin
                pos = lowest_free();
                if (pos >= 0) begin
                    rsp.found      = 1'b1;
                    rsp.free_index = pos[INDEX_W-1:0];
                end
            end else if (req.bit_index >= usable_bits()) begin
                rsp.range_error = 1'b1;
            end else begin
                case (req.command)
                    CMD_SET:   used_bits[req.bit_index] = 1'b1;
                    CMD_CLEAR: used_bits[req.bit_index] = 1'b0;
                    default:   rsp.bit_value = used_bits[req.bit_index];
                endcase
            end
            pending_answers.push_back(rsp);
        endfunction

        task report(string what);
            if (mismatches < 100) $display("%0t mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(t_rsp got);
            t_rsp want;
            if (pending_answers.size() == 0) begin
                report($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = pending_answers.pop_front();
            if (got.found !== want.found)
                report($sformatf("found %b, want %b", got.found, want.found));
            if (got.free_index !== want.free_index)
                report($sformatf("free_index %0d, want %0d", got.free_index, want.free_index));
            if (got.bit_value !== want.bit_value)
                report($sformatf("bit_value %b, want %b", got.bit_value, want.bit_value));
            if (got.range_error !== want.range_error)
                report($sformatf("range_error %b, want %b", got.range_error, want.range_error));
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    t_req             i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_rsp             o_out_data;

    alloc_map_tracker tracker = new();
    bit               in_idle_en;
    bit               out_idle_en;
    int               hold_request;
    int unsigned      cycle_count = 0;

    free_bit_allocation_map_core #(
        .MAP_BITS(MAP_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("free_bit_allocation_map_core_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) tracker.check_result(o_out_data);
    end

    // result side: long hold-off on request, otherwise random stall bursts if idling is on
    initial begin
        int hold_left;
        int stall_left;
        hold_left   = 0;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else if (out_idle_en && $urandom_range(0, 7) == 0) begin
                i_out_ready = 1'b0;
                stall_left  = $urandom_range(0, 9);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    function automatic int unsigned index_below(input int unsigned limit);
        if (limit == 0) return $urandom_range(0, MAP_BITS - 1);
        return $urandom_range(0, limit - 1);
    endfunction

    task automatic send_request(input logic [1:0] command, input int unsigned index);
        t_req req;
        req.command   = command;
        req.bit_index = index[INDEX_W-1:0];
        if (in_idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.note_request(req);
        @(negedge i_clk);
    endtask

    task automatic write_bits_in_use(input logic [CFG_W-1:0] count);
        i_in_valid = 1'b0;
        while (tracker.pending_count() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = count;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.bits_in_use = count;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // mostly allocate/release traffic, plus tests, bare finds and noise
    task automatic run_random(input int items);
        int          sent;
        int          pick;
        int          free_pos;
        int unsigned limit;
        sent = 0;
        while (sent < items) begin
            limit = tracker.usable_bits();
            pick  = $urandom_range(0, 99);
            if (pick < 35) begin
                send_request(CMD_FIND, $urandom_range(0, MAP_BITS - 1));
                free_pos = tracker.lowest_free();
                if (free_pos >= 0) send_request(CMD_SET, free_pos);
                else send_request(CMD_SET, index_below(limit));
                sent += 2;
            end else if (pick < 55) begin
                free_pos = tracker.lowest_free();
                if (free_pos > 0) send_request(CMD_CLEAR, $urandom_range(0, free_pos - 1));
                else send_request(CMD_CLEAR, index_below(limit));
                sent++;
            end else if (pick < 70) begin
                send_request(CMD_TEST, index_below(limit));
                sent++;
            end else if (pick < 80) begin
                send_request(CMD_FIND, $urandom_range(0, MAP_BITS - 1));
                sent++;
            end else begin
                send_request(2'($urandom_range(0, 3)), $urandom_range(0, MAP_BITS - 1));
                sent++;
            end
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] count, input int items, input bit idle,
                             input int hold);
        write_bits_in_use(count);
        in_idle_en   = idle;
        out_idle_en  = idle;
        hold_request = hold;
        run_random(items);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        in_idle_en   = 1'b1;
        out_idle_en  = 1'b1;
        hold_request = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // full map after reset
        send_request(CMD_FIND, 0);
        send_request(CMD_SET, 0);
        send_request(CMD_SET, 1);
        send_request(CMD_FIND, 1023);
        send_request(CMD_TEST, 1);
        send_request(CMD_TEST, 2);
        send_request(CMD_CLEAR, 0);
        send_request(CMD_FIND, 0);
        send_request(CMD_SET, 1023);
        send_request(CMD_TEST, 1023);
        send_request(CMD_CLEAR, 1023);
        send_request(CMD_TEST, 1023);
        send_request(CMD_TEST, 0);

        // nothing in use: set, clear and test are out of range, find finds nothing
        write_bits_in_use(11'd0);
        send_request(CMD_FIND, 0);
        send_request(CMD_SET, 0);
        send_request(CMD_CLEAR, 1023);
        send_request(CMD_TEST, 5);

        // two bits in use: search stops at the count
        write_bits_in_use(11'd2);
        send_request(CMD_FIND, 0);
        send_request(CMD_SET, 0);
        send_request(CMD_FIND, 0);
        send_request(CMD_SET, 2);
        send_request(CMD_TEST, 1);

        // count above the map size acts as the full map
        write_bits_in_use(11'd2047);
        send_request(CMD_FIND, 0);
        send_request(CMD_TEST, 1023);

        run_phase(11'd1024, 150, 1'b1, 0);
        run_phase(11'd33, 120, 1'b1, 300);
        run_phase(11'd64, 120, 1'b0, 0);
        run_phase(11'd0, 40, 1'b1, 0);
        run_phase(11'd1, 40, 1'b1, 0);
        run_phase(11'd2047, 200, 1'b1, 0);
        run_phase(CFG_W'($urandom_range(1, 1024)), 150, 1'b1, 0);
        run_phase(11'd32, 80, 1'b1, 0);
        run_phase(11'd1023, 100, 1'b1, 0);
        run_phase(11'd1024, 150, 1'b0, 0);

        i_in_valid = 1'b0;
        while (tracker.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_count() == 0) begin
            $display("free_bit_allocation_map_core_tb passed");
        end else begin
            $display("free_bit_allocation_map_core_tb failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== free_bit_allocation_map_core.f =====
src/fbam_pkg.sv
src/fbam_ctrl.sv
src/fbam_dp.sv
src/free_bit_allocation_map_core.sv
test/free_bit_allocation_map_core_tb.sv
